/* rtl/core/avsdp_pkg.sv */
// shared types and codes of the container demux parser
package avsdp_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned KIND_W = 3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_VIDEO  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AUDIO  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AFMT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EOS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FMTERR = 3'd4;

    // block types
    localparam logic [7:0] BT_VIDEO   = 8'h01;
    localparam logic [7:0] BT_AUDIO   = 8'h02;
    localparam logic [7:0] BT_PALETTE = 8'h03;

    // header lengths
    localparam logic [15:0] BLOCK_HDR_LEN = 16'd4;
    localparam logic [15:0] CHUNK_HDR_LEN = 16'd6;
    localparam logic [23:0] CHUNK_TRIM    = 24'd2;

    // configuration register indexes
    localparam logic [7:0] REG_VIDEO_ENABLE = 8'd0;
    localparam logic [7:0] REG_AUDIO_ENABLE = 8'd1;

    // one queue entry: up to four results of the same kind caused by one byte
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [1:0]              last_idx;
        logic                    pend_last;
        logic [3:0][DATA_W-1:0]  data;
    } res_entry_t;

endpackage

/* rtl/core/avs_container_demux_parser.sv */
// container demux parser: one byte per cycle in, results one per cycle out
// each result is written into the result queue as the byte that causes it is accepted
// throughput: one byte per cycle while the result queue (QUEUE_DEPTH entries) has room;
// results leave one per cycle with m_tready high; a video or palette header can give four
// reset: aresetn clears the parser to the frame header phase, empties the queue and
// sets both stream enables to 1
module avs_container_demux_parser
    import avsdp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [7:0] value
    output logic [3:0]        m_tuser,   // [2:0] kind, [3] packet_end
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic              cfg_data
);

    logic       q_full, q_empty, q_pop, push_valid, in_accept;
    res_entry_t push_entry, q_head;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    avsdp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    avsdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    avsdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/avsdp_front.sv */
// byte parser: tracks frame and block structure and produces result entries
module avsdp_front
    import avsdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [DATA_W-1:0] in_byte,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_index,
    input  logic              cfg_data,
    output logic              push_valid,
    output res_entry_t        push_entry
);

    typedef enum logic [2:0] {
        PH_FHDR  = 3'd0,
        PH_BHDR  = 3'd1,
        PH_SKIP  = 3'd2,
        PH_VID   = 3'd3,
        PH_PAL   = 3'd4,
        PH_AHDR  = 3'd5,
        PH_ADATA = 3'd6,
        PH_HALT  = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] fpos_reg, fpos_next;
    logic [15:0] flen_reg, flen_next;
    logic [2:0]  hc_reg, hc_next;
    logic [31:0] hb_reg, hb_next;
    logic [15:0] br_reg, br_next;
    logic [23:0] ar_reg, ar_next;
    logic        aopen_reg, aopen_next;
    logic        vopen_reg, vopen_next;
    logic        ven_reg, aen_reg;

    logic        e_valid;
    res_entry_t  e;
    logic        do_end, do_acont;
    logic [7:0]  btype;
    logic [15:0] bsize;
    logic [23:0] csize;

    always_comb begin
        phase_next = phase_reg;
        fpos_next  = fpos_reg;
        flen_next  = flen_reg;
        hc_next    = hc_reg;
        hb_next    = hb_reg;
        br_next    = br_reg;
        ar_next    = ar_reg;
        aopen_next = aopen_reg;
        vopen_next = vopen_reg;
        e_valid    = 1'b0;
        e          = '0;
        do_end     = 1'b0;
        do_acont   = 1'b0;
        btype      = '0;
        bsize      = '0;
        csize      = '0;

        if (phase_reg != PH_FHDR && phase_reg != PH_HALT && fpos_reg != 16'hFFFF) begin
            fpos_next = fpos_reg + 16'd1;
        end

        // header byte collection shared by the header phases
        if (phase_reg == PH_FHDR || phase_reg == PH_BHDR || phase_reg == PH_AHDR) begin
            if (hc_reg == 3'd0) begin
                hb_next = '0;
            end
            if (hc_reg < 3'd4) begin
                case (hc_reg[1:0])
                    2'd0: hb_next[7:0]   = in_byte;
                    2'd1: hb_next[15:8]  = in_byte;
                    2'd2: hb_next[23:16] = in_byte;
                    default: hb_next[31:24] = in_byte;
                endcase
            end
            hc_next = hc_reg + 3'd1;
        end

        unique case (phase_reg)
            PH_FHDR: begin
                if (hc_next == 3'd2 && hb_next[15:0] == 16'd0) begin
                    e_valid    = 1'b1;
                    e.kind     = KIND_EOS;
                    phase_next = PH_HALT;
                end else if (hc_next == 3'd4) begin
                    flen_next = hb_next[31:16];
                    fpos_next = 16'd4;
                    do_end    = 1'b1;
                end
            end
            PH_BHDR: begin
                if (hc_next == 3'd4) begin
                    btype   = hb_next[15:8];
                    bsize   = hb_next[31:16];
                    br_next = (bsize < BLOCK_HDR_LEN) ? 16'd0 : bsize - BLOCK_HDR_LEN;
                    hc_next = 3'd0;
                    if (btype == BT_VIDEO && ven_reg) begin
                        e_valid     = 1'b1;
                        e.kind      = KIND_VIDEO;
                        e.last_idx  = 2'd3;
                        e.data      = hb_next;
                        e.pend_last = (br_next == 16'd0);
                        if (br_next == 16'd0) begin
                            vopen_next = 1'b0;
                            do_end     = 1'b1;
                        end else begin
                            vopen_next = 1'b1;
                            phase_next = PH_VID;
                        end
                    end else if (btype == BT_PALETTE && ven_reg) begin
                        e_valid = 1'b1;
                        if (vopen_reg) begin
                            e.kind     = KIND_FMTERR;
                            phase_next = PH_HALT;
                        end else begin
                            e.kind     = KIND_VIDEO;
                            e.last_idx = 2'd3;
                            e.data     = hb_next;
                            vopen_next = 1'b1;
                            if (br_next == 16'd0) begin
                                do_end = 1'b1;
                            end else begin
                                phase_next = PH_PAL;
                            end
                        end
                    end else if (btype == BT_AUDIO && aen_reg) begin
                        do_acont = 1'b1;
                    end else if (br_next == 16'd0) begin
                        do_end = 1'b1;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                br_next = br_reg - 16'd1;
                if (br_next == 16'd0) begin
                    do_end = 1'b1;
                end
            end
            PH_VID, PH_PAL: begin
                br_next     = br_reg - 16'd1;
                e_valid     = 1'b1;
                e.kind      = KIND_VIDEO;
                e.data[0]   = in_byte;
                e.pend_last = (phase_reg == PH_VID) && (br_next == 16'd0);
                if (br_next == 16'd0) begin
                    if (phase_reg == PH_VID) begin
                        vopen_next = 1'b0;
                    end
                    do_end = 1'b1;
                end
            end
            PH_AHDR: begin
                br_next = br_reg - 16'd1;
                csize   = hb_next[31:8];
                if (hc_next == 3'd5) begin
                    e_valid     = 1'b1;
                    e.kind      = KIND_AFMT;
                    e.data[0]   = in_byte;
                    e.pend_last = (csize <= CHUNK_TRIM);
                end else if (hc_next == 3'd6) begin
                    hc_next    = 3'd0;
                    ar_next    = (csize < CHUNK_TRIM) ? 24'd0 : csize - CHUNK_TRIM;
                    aopen_next = (ar_next != 24'd0);
                    do_acont   = 1'b1;
                end
            end
            PH_ADATA: begin
                br_next     = br_reg - 16'd1;
                ar_next     = ar_reg - 24'd1;
                e_valid     = 1'b1;
                e.kind      = KIND_AUDIO;
                e.data[0]   = in_byte;
                e.pend_last = (ar_next == 24'd0);
                if (ar_next == 24'd0) begin
                    aopen_next = 1'b0;
                end
                do_acont = 1'b1;
            end
            PH_HALT: begin
            end
        endcase

        // continue inside an audio block
        if (do_acont) begin
            if (br_next == 16'd0) begin
                do_end = 1'b1;
            end else if (aopen_next) begin
                phase_next = PH_ADATA;
            end else if (br_next < CHUNK_HDR_LEN) begin
                phase_next = PH_SKIP;
            end else begin
                hc_next    = 3'd0;
                phase_next = PH_AHDR;
            end
        end

        // block done: next frame header once the frame length is reached
        if (do_end) begin
            hc_next    = 3'd0;
            phase_next = (fpos_next >= flen_next) ? PH_FHDR : PH_BHDR;
        end
    end

    assign push_valid = in_accept && e_valid;
    assign push_entry = e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FHDR;
            fpos_reg  <= '0;
            flen_reg  <= '0;
            hc_reg    <= '0;
            hb_reg    <= '0;
            br_reg    <= '0;
            ar_reg    <= '0;
            aopen_reg <= 1'b0;
            vopen_reg <= 1'b0;
            ven_reg   <= 1'b1;
            aen_reg   <= 1'b1;
        end else begin
            if (in_accept) begin
                phase_reg <= phase_next;
                fpos_reg  <= fpos_next;
                flen_reg  <= flen_next;
                hc_reg    <= hc_next;
                hb_reg    <= hb_next;
                br_reg    <= br_next;
                ar_reg    <= ar_next;
                aopen_reg <= aopen_next;
                vopen_reg <= vopen_next;
            end
            if (cfg_valid) begin
                if (cfg_index == REG_VIDEO_ENABLE) begin
                    ven_reg <= cfg_data;
                end else if (cfg_index == REG_AUDIO_ENABLE) begin
                    aen_reg <= cfg_data;
                end
            end
        end
    end

endmodule

/* rtl/core/avsdp_queue.sv */
// small register queue of result entries between parser and output stage
module avsdp_queue
    import avsdp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  res_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output res_entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    res_entry_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/avsdp_back.sv */
// output stage: walks the results of the head entry one item at a time
module avsdp_back
    import avsdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  res_entry_t        q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);

    logic [1:0] sub_reg, sub_next;
    logic       is_last;
    logic       out_acc;

    assign is_last  = (sub_reg == q_head.last_idx);
    assign m_tvalid = !q_empty;
    assign out_acc  = m_tvalid && m_tready;
    assign q_pop    = out_acc && is_last;
    assign m_tdata  = q_head.data[sub_reg];
    assign m_tuser  = {is_last && q_head.pend_last, q_head.kind};
    assign m_tlast  = is_last;

    always_comb begin
        sub_next = sub_reg;
        if (out_acc) begin
            sub_next = is_last ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= '0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

/* test/tb_top.sv */
// testbench top for the container demux parser: byte stream stimulus, prediction and checks
`timescale 1ns / 100ps

module tb_top
    import avsdp_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned RANDOM_BYTES = 150;
    localparam logic [7:0]  BT_OTHER = 8'h7E;
    // indexes past the register map, writes there must change nothing
    localparam logic [7:0]  NO_REG_LOW  = 8'd2;
    localparam logic [7:0]  NO_REG_HIGH = 8'hFF;

    typedef enum logic [2:0] {
        PS_FRAME_HDR, PS_BLOCK_HDR, PS_SKIP, PS_VIDEO,
        PS_PALETTE, PS_CHUNK_HDR, PS_AUDIO, PS_HALT
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        value;
        logic              pend;
        logic              last;
    } demux_out_t;

    class demux_tracker;
        bit                vid_en;
        bit                aud_en;
        parse_state_t      state;
        logic [15:0]       frame_pos;
        logic [15:0]       frame_len;
        logic [2:0]        hdr_cnt;
        logic [31:0]       hdr;
        logic [15:0]       blk_rem;
        logic [23:0]       aud_rem;
        bit                aud_open;
        bit                vid_open;
        demux_out_t        demux_out_q[$];
        int                errors;

        function new();
            vid_en = 1'b1;
            aud_en = 1'b1;
            state = PS_FRAME_HDR;
            frame_pos = '0;
            frame_len = '0;
            hdr_cnt = '0;
            hdr = '0;
            blk_rem = '0;
            aud_rem = '0;
            aud_open = 1'b0;
            vid_open = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic d);
            if (idx == REG_VIDEO_ENABLE)
                vid_en = d;
            else if (idx == REG_AUDIO_ENABLE)
                aud_en = d;
        endfunction

        function void add(logic [KIND_W-1:0] kind, logic [7:0] value, logic pend);
            demux_out_t r;
            r.kind = kind;
            r.value = value;
            r.pend = pend;
            r.last = 1'b0;
            demux_out_q.push_back(r);
        endfunction

        function void collect(logic [7:0] b);
            if (hdr_cnt == 0)
                hdr = '0;
            if (hdr_cnt < 4)
                hdr = hdr | ({24'd0, b} << (8 * hdr_cnt));
            hdr_cnt++;
        endfunction

        function void close_block();
            hdr_cnt = '0;
            state = (frame_pos >= frame_len) ? PS_FRAME_HDR : PS_BLOCK_HDR;
        endfunction

        function void audio_next();
            if (blk_rem == 0) begin
                close_block();
            end else if (aud_open) begin
                state = PS_AUDIO;
            end else if (blk_rem < CHUNK_HDR_LEN) begin
                state = PS_SKIP;
            end else begin
                hdr_cnt = '0;
                state = PS_CHUNK_HDR;
            end
        endfunction

        function void skip_rest();
            if (blk_rem == 0)
                close_block();
            else
                state = PS_SKIP;
        endfunction

        function void header_out(logic pend_last);
            for (int i = 0; i < 4; i++)
                add(KIND_VIDEO, hdr[8*i +: 8], (i == 3) ? pend_last : 1'b0);
        endfunction

        function void block_start();
            logic [7:0]  btype;
            logic [15:0] bsize;
            btype = hdr[15:8];
            bsize = hdr[31:16];
            blk_rem = (bsize < BLOCK_HDR_LEN) ? 16'd0 : bsize - BLOCK_HDR_LEN;
            hdr_cnt = '0;
            if (btype == BT_VIDEO && vid_en) begin
                if (blk_rem == 0) begin
                    header_out(1'b1);
                    vid_open = 1'b0;
                    close_block();
                end else begin
                    header_out(1'b0);
                    vid_open = 1'b1;
                    state = PS_VIDEO;
                end
            end else if (btype == BT_PALETTE && vid_en) begin
                if (vid_open) begin
                    add(KIND_FMTERR, 8'd0, 1'b0);
                    state = PS_HALT;
                end else begin
                    header_out(1'b0);
                    vid_open = 1'b1;
                    if (blk_rem == 0)
                        close_block();
                    else
                        state = PS_PALETTE;
                end
            end else if (btype == BT_AUDIO && aud_en) begin
                audio_next();
            end else begin
                skip_rest();
            end
        endfunction

        // works out the results of one accepted byte and queues them
        function void parse_byte(logic [7:0] b);
            int         n0;
            demux_out_t tail;
            n0 = demux_out_q.size();
            if (state != PS_FRAME_HDR && state != PS_HALT && frame_pos != 16'hFFFF)
                frame_pos++;
            case (state)
                PS_FRAME_HDR: begin
                    collect(b);
                    if (hdr_cnt == 2 && hdr[15:0] == 16'd0) begin
                        add(KIND_EOS, 8'd0, 1'b0);
                        state = PS_HALT;
                    end else if (hdr_cnt == 4) begin
                        frame_len = hdr[31:16];
                        frame_pos = BLOCK_HDR_LEN;
                        close_block();
                    end
                end
                PS_BLOCK_HDR: begin
                    collect(b);
                    if (hdr_cnt == 4)
                        block_start();
                end
                PS_SKIP: begin
                    blk_rem--;
                    if (blk_rem == 0)
                        close_block();
                end
                PS_VIDEO, PS_PALETTE: begin
                    blk_rem--;
                    add(KIND_VIDEO, b, (state == PS_VIDEO && blk_rem == 0));
                    if (blk_rem == 0) begin
                        if (state == PS_VIDEO)
                            vid_open = 1'b0;
                        close_block();
                    end
                end
                PS_CHUNK_HDR: begin
                    collect(b);
                    blk_rem--;
                    if (hdr_cnt == 5) begin
                        add(KIND_AFMT, b, (hdr[31:8] <= CHUNK_TRIM));
                    end else if (hdr_cnt == 6) begin
                        hdr_cnt = '0;
                        aud_rem = (hdr[31:8] < CHUNK_TRIM) ? 24'd0 : hdr[31:8] - CHUNK_TRIM;
                        aud_open = (aud_rem != 0);
                        audio_next();
                    end
                end
                PS_AUDIO: begin
                    blk_rem--;
                    aud_rem--;
                    if (aud_rem == 0) begin
                        aud_open = 1'b0;
                        add(KIND_AUDIO, b, 1'b1);
                    end else begin
                        add(KIND_AUDIO, b, 1'b0);
                    end
                    audio_next();
                end
                default: ;
            endcase
            if (demux_out_q.size() > n0) begin
                tail = demux_out_q.pop_back();
                tail.last = 1'b1;
                demux_out_q.push_back(tail);
            end
        endfunction

        function void cmp_field(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void compare_output(logic [KIND_W-1:0] kind, logic [7:0] value,
                                     logic pend, logic last);
            demux_out_t e;
            if (demux_out_q.size() == 0) begin
                $error("result with none outstanding: kind %0h value %0h", kind, value);
                errors++;
                return;
            end
            e = demux_out_q.pop_front();
            cmp_field("kind", e.kind, kind);
            cmp_field("value", e.value, value);
            cmp_field("packet_end", e.pend, pend);
            cmp_field("run_last", e.last, last);
        endfunction

        function int outstanding();
            return demux_out_q.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [3:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = '0;
    logic              cfg_data = 1'b0;

    demux_tracker sb;
    logic [7:0]   tx_q[$];
    logic [7:0]   frame_body[$];
    bit           no_idle = 1'b0;
    bit           hold_req = 1'b0;
    int unsigned  cycle_cnt = 0;
    // generator's view of the stream, kept in step with what it has built
    bit           gen_v_en = 1'b1;
    bit           gen_a_en = 1'b1;
    bit           pal_open_gen = 1'b0;
    int           aud_left_gen = 0;

    avs_container_demux_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        int g;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.compare_output(m_tuser[2:0], m_tdata, m_tuser[3], m_tlast);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                g = ($urandom_range(0, 3) == 0) ? gap_cycles() : 0;
                if (g > 0) begin
                    stall_left = g - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_queued();
        logic [7:0] b;
        int         g;
        while (tx_q.size() > 0) begin
            b = tx_q.pop_front();
            g = gap_cycles();
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= b;
            do @(posedge aclk); while (!s_tready);
            sb.parse_byte(b);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
    endtask

    task automatic set_streams(input bit v, input bit a, input bit junk);
        wait_idle();
        cfg_write(REG_VIDEO_ENABLE, v);
        if (junk) begin
            cfg_write(NO_REG_LOW, ~v);
            cfg_write(NO_REG_HIGH, ~a);
        end
        cfg_write(REG_AUDIO_ENABLE, a);
        cfg_valid <= 1'b0;
        gen_v_en = v;
        gen_a_en = a;
    endtask

    function automatic void push_noise(int n);
        repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
    endfunction

    // audio block payload laid out as chunk headers and chunk data
    function automatic void fill_audio(int n);
        int k;
        int csize;
        int r;
        while (n > 0) begin
            if (aud_left_gen > 0) begin
                k = (aud_left_gen < n) ? aud_left_gen : n;
                push_noise(k);
                aud_left_gen -= k;
                n -= k;
            end else if (n < 6) begin
                push_noise(n);
                n = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    csize = $urandom_range(0, 2);
                else if (r < 89)
                    csize = $urandom_range(3, 30);
                else if (r < 99)
                    csize = $urandom_range(31, 400);
                else
                    csize = $urandom_range(0, 24'hFFFFFF);
                frame_body.push_back(8'($urandom_range(0, 255)));
                frame_body.push_back(8'(csize));
                frame_body.push_back(8'(csize >> 8));
                frame_body.push_back(8'(csize >> 16));
                push_noise(2);
                n -= 6;
                aud_left_gen = (csize < 2) ? 0 : csize - 2;
            end
        end
    endfunction

    task automatic gen_frame(input bit huge);
        int          nblk;
        int          eff;
        int          last_eff;
        int          total;
        int          r;
        logic [15:0] size;
        logic [15:0] flen;
        logic [15:0] word;
        logic [7:0]  btype;
        frame_body.delete();
        last_eff = 0;
        nblk = huge ? 1 : $urandom_range(0, 3);
        for (int i = 0; i < nblk; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                btype = BT_VIDEO;
            end else if (r < 35) begin
                btype = (pal_open_gen && gen_v_en) ? BT_VIDEO : BT_PALETTE;
            end else if (r < 75) begin
                btype = BT_AUDIO;
            end else begin
                btype = 8'($urandom_range(0, 255));
                if (btype == BT_PALETTE && pal_open_gen && gen_v_en)
                    btype = BT_OTHER;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                size = 16'($urandom_range(0, 3));
            else if (r < 95)
                size = 16'($urandom_range(4, 24));
            else
                size = 16'($urandom_range(25, 124));
            if (huge) begin
                btype = BT_OTHER;
                size = 16'hFFFF;
            end
            eff = (size < BLOCK_HDR_LEN) ? 4 : size;
            frame_body.push_back(8'($urandom_range(0, 255)));
            frame_body.push_back(btype);
            frame_body.push_back(size[7:0]);
            frame_body.push_back(size[15:8]);
            if (btype == BT_AUDIO && gen_a_en)
                fill_audio(eff - 4);
            else
                push_noise(eff - 4);
            if (gen_v_en && btype == BT_PALETTE)
                pal_open_gen = 1'b1;
            else if (gen_v_en && btype == BT_VIDEO)
                pal_open_gen = 1'b0;
            last_eff = eff;
        end
        total = 4 + frame_body.size();
        if (huge)
            flen = 16'hFFFF;
        else if (nblk == 0)
            flen = 16'($urandom_range(0, 4));
        else if ($urandom_range(0, 4) == 0)
            flen = 16'($urandom_range(total - last_eff + 1, total));  // frame length hit in last block
        else
            flen = 16'(total);
        word = 16'($urandom_range(1, 16'hFFFF));
        tx_q.push_back(word[7:0]);
        tx_q.push_back(word[15:8]);
        tx_q.push_back(flen[7:0]);
        tx_q.push_back(flen[15:8]);
        foreach (frame_body[i])
            tx_q.push_back(frame_body[i]);
    endtask

    initial begin : stimulus
        int phase_no;
        int rand_bytes;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // palette, short video closing it, video without palette, short chunk,
        // too little room for a chunk header, unknown block, empty frame
        tx_q = '{8'h01, 8'h00, 8'h22, 8'h00,
                 8'h00, BT_PALETTE, 8'h04, 8'h00,
                 8'h00, BT_VIDEO, 8'h02, 8'h00,
                 8'h00, BT_VIDEO, 8'h05, 8'h00, 8'hFF,
                 8'h00, BT_AUDIO, 8'h0C, 8'h00,
                 8'h00, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55,
                 8'h00, 8'hFF, 8'h05, 8'h00, 8'h00,
                 8'h00, 8'hFF, 8'h00, 8'h00};
        send_queued();

        phase_no = 0;
        rand_bytes = 0;
        while (phase_no < 4 || rand_bytes < RANDOM_BYTES) begin
            case (phase_no)
                0: set_streams(1'b0, 1'b1, 1'b1);
                1: set_streams(1'b1, 1'b0, 1'b0);
                2: set_streams(1'b0, 1'b0, 1'b0);
                3: set_streams(1'b1, 1'b1, 1'b0);
                default: set_streams(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
            endcase
            no_idle = (phase_no == 3);
            if (phase_no == 3) begin
                // long video block sent while the result side holds off
                hold_req = 1'b1;
                tx_q = '{8'h02, 8'h00, 8'h1C, 8'h00,
                         8'h00, BT_VIDEO, 8'h18, 8'h00};
                repeat (20) tx_q.push_back(8'($urandom_range(0, 255)));
                pal_open_gen = 1'b0;
            end
            repeat ($urandom_range(1, 2)) gen_frame(1'b0);
            rand_bytes += tx_q.size();
            send_queued();
            phase_no++;
        end

        // one halt per run: end of stream or a second palette
        no_idle = 1'b0;
        set_streams(1'b1, 1'b1, 1'b0);
        if ($urandom_range(0, 1) == 0)
            tx_q = '{8'h00, 8'h00};
        else
            tx_q = '{8'h01, 8'h00, 8'h0D, 8'h00,
                     8'h00, BT_PALETTE, 8'h04, 8'h00,
                     8'h00, BT_PALETTE, 8'h05, 8'h00, 8'hFF};
        repeat (6) tx_q.push_back(8'($urandom_range(0, 255)));
        send_queued();
        wait_idle();
        repeat (10) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
